[rtl/core/footswitch_press_classifier_defines.svh]
// Assertion macros shared by the footswitch press classifier RTL.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef FOOTSWITCH_PRESS_CLASSIFIER_DEFINES_SVH
`define FOOTSWITCH_PRESS_CLASSIFIER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define FPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fpc_pkg.sv]
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the footswitch press classifier.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Press classification codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE   = 2'd0;
    localparam t_kind KIND_NORMAL = 2'd1;
    localparam t_kind KIND_DOUBLE = 2'd2;
    localparam t_kind KIND_LONG   = 2'd3;

    // Configuration register indexes
    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_DOUBLE_WINDOW = 1'b0;
    localparam t_cfg_idx CFG_LONG_PRESS    = 1'b1;

    // Configuration widths and reset values
    localparam int CFG_BITS = 16;
    localparam logic [CFG_BITS-1:0] DOUBLE_WINDOW_RST = 16'd600;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RST    = 16'd2000;

    // Repeat press counter
    typedef logic [1:0] t_count;
    localparam t_count COUNT_MAX = 2'd3;
    localparam t_count COUNT_ONE = 2'd1;
    localparam t_count COUNT_TWO = 2'd2;

    // Event from the press tracker to the mode logic
    typedef struct packed {
        t_kind kind;
        logic  sw;
    } t_press_evt;

endpackage

[rtl/core/fpc_press_track.sv]
// ----------------------------------------------------------------------------
// fpc_press_track
// Per-switch press tracking: edge detection, repeat press counting, hold
// timing and long-press marking. One lane per switch; the lane named by the
// sample updates its state when the beat is processed.
// ----------------------------------------------------------------------------
module fpc_press_track #(
    parameter int NUM_SWITCHES = 2,
    parameter int TIME_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_sw,
    input  logic                          i_lvl,
    input  logic [TIME_BITS-1:0]          i_now,
    input  logic [fpc_pkg::CFG_BITS-1:0]  i_window,
    input  logic [fpc_pkg::CFG_BITS-1:0]  i_long_ms,
    output fpc_pkg::t_press_evt           o_evt
);

    logic [TIME_BITS-1:0] window_ext;
    logic [TIME_BITS-1:0] long_ext;
    fpc_pkg::t_kind       lane_kind [NUM_SWITCHES];

    assign window_ext = TIME_BITS'(i_window);
    assign long_ext   = TIME_BITS'(i_long_ms);

    genvar g;
    generate
        for (g = 0; g < NUM_SWITCHES; g++) begin : g_lane
            logic                 r_lvl;
            logic [TIME_BITS-1:0] r_start;
            logic [TIME_BITS-1:0] r_last;
            fpc_pkg::t_count      r_cnt;
            logic                 r_long;

            logic                 hit;
            logic                 press_edge;
            logic [TIME_BITS-1:0] start_eff;
            logic [TIME_BITS-1:0] gap;
            logic [TIME_BITS-1:0] dur;
            fpc_pkg::t_count      cnt_eff;
            logic                 long_eff;
            logic                 long_hit;
            logic                 release_ok;
            logic                 dbl;
            logic                 nrm;

            assign hit        = i_fire && (i_sw == 1'(g));
            assign press_edge = i_lvl && !r_lvl;
            assign start_eff  = press_edge ? i_now : r_start;
            assign gap        = i_now - r_last;
            assign dur        = i_now - start_eff;
            assign long_eff   = press_edge ? 1'b0 : r_long;

            // Repeat count: step within the window, else restart at one
            always_comb begin
                cnt_eff = r_cnt;
                if (press_edge) begin
                    if (gap <= window_ext) begin
                        cnt_eff = (r_cnt == fpc_pkg::COUNT_MAX) ? fpc_pkg::COUNT_MAX
                                                                 : r_cnt + 2'd1;
                    end else begin
                        cnt_eff = fpc_pkg::COUNT_ONE;
                    end
                end
            end

            // Classification
            assign long_hit   = i_lvl && (dur >= long_ext) && !long_eff;
            assign release_ok = !i_lvl && r_lvl && !long_eff;
            assign dbl        = release_ok && (cnt_eff >= fpc_pkg::COUNT_TWO);
            assign nrm        = release_ok && (cnt_eff < fpc_pkg::COUNT_TWO) &&
                                (dur < long_ext);

            always_comb begin
                lane_kind[g] = fpc_pkg::KIND_NONE;
                if (hit) begin
                    if (long_hit) begin
                        lane_kind[g] = fpc_pkg::KIND_LONG;
                    end else if (dbl) begin
                        lane_kind[g] = fpc_pkg::KIND_DOUBLE;
                    end else if (nrm) begin
                        lane_kind[g] = fpc_pkg::KIND_NORMAL;
                    end
                end
            end

            // Lane state
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_lvl   <= 1'b0;
                    r_start <= '0;
                    r_last  <= '0;
                    r_cnt   <= '0;
                    r_long  <= 1'b0;
                end else if (hit) begin
                    r_lvl   <= i_lvl;
                    r_start <= start_eff;
                    r_last  <= press_edge ? i_now : r_last;
                    r_cnt   <= dbl ? '0 : cnt_eff;
                    r_long  <= long_hit ? 1'b1 : long_eff;
                end
            end
        end
    endgenerate

    // Only the addressed lane reports, so the lanes are OR-ed together
    always_comb begin
        o_evt.kind = fpc_pkg::KIND_NONE;
        for (int k = 0; k < NUM_SWITCHES; k++) begin
            o_evt.kind = o_evt.kind | lane_kind[k];
        end
        o_evt.sw = i_sw;
    end

endmodule

[rtl/core/footswitch_press_classifier.sv]
// ----------------------------------------------------------------------------
// footswitch_press_classifier
// Classifies footswitch presses as normal, double or long and drives the
// effect bypass flags, the reverb edit mode and the save request.
// ----------------------------------------------------------------------------
// One sample is taken per clock unless o_stall is high, and every sample
// yields exactly one result, held in the input register and then in the
// result register. The rate is set by the single pass through the press
// tracker and mode logic, which reads and writes the per-switch state in the
// same cycle. The input register also absorbs one beat while a result is
// held by downstream stall. Timestamps are compared modulo 2^TIME_BITS.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module footswitch_press_classifier #(
    parameter int NUM_SWITCHES = 2,
    parameter int TIME_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // sample channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_switch_index,
    input  logic        i_pressed,
    input  logic [31:0] i_now_ms,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_press_kind,
    output logic        o_reverb_bypassed,
    output logic        o_delay_bypassed,
    output logic        o_trem_bypassed,
    output logic        o_edit_mode,
    output logic        o_save_request
);

    `include "footswitch_press_classifier_defines.svh"

    logic [fpc_pkg::CFG_BITS-1:0] r_window;
    logic [fpc_pkg::CFG_BITS-1:0] r_long_ms;

    logic                 r_in_vld;
    logic                 r_in_sw;
    logic                 r_in_lvl;
    logic [TIME_BITS-1:0] r_in_now;

    logic                 r_out_vld;
    fpc_pkg::t_kind       r_out_kind;
    logic                 r_out_save;

    logic                 r_rev;
    logic                 r_del;
    logic                 r_trem;
    logic                 r_edit;

    logic                 n_rev;
    logic                 n_del;
    logic                 n_trem;
    logic                 n_edit;
    logic                 n_save;

    logic                 fire;
    logic                 in_take;
    fpc_pkg::t_press_evt  evt;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= fpc_pkg::DOUBLE_WINDOW_RST;
            r_long_ms <= fpc_pkg::LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fpc_pkg::CFG_DOUBLE_WINDOW: r_window  <= i_cfg_data;
                fpc_pkg::CFG_LONG_PRESS:    r_long_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: process when the result register is free or being emptied
    assign fire    = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && r_out_vld && i_stall;
    assign in_take = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sw  <= i_switch_index;
            r_in_lvl <= i_pressed;
            r_in_now <= i_now_ms[TIME_BITS-1:0];
        end
    end

    // Per-switch press tracking
    fpc_press_track #(
        .NUM_SWITCHES (NUM_SWITCHES),
        .TIME_BITS    (TIME_BITS)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_sw      (r_in_sw),
        .i_lvl     (r_in_lvl),
        .i_now     (r_in_now),
        .i_window  (r_window),
        .i_long_ms (r_long_ms),
        .o_evt     (evt)
    );

    // Mode logic
    always_comb begin
        n_rev  = r_rev;
        n_del  = r_del;
        n_trem = r_trem;
        n_edit = r_edit;
        n_save = 1'b0;
        case (evt.kind)
            fpc_pkg::KIND_NORMAL: begin
                if (r_edit) begin
                    n_save = 1'b1;
                    n_edit = 1'b0;
                end else if (!evt.sw) begin
                    n_rev = !r_rev;
                end else begin
                    n_del = !r_del;
                end
            end
            fpc_pkg::KIND_DOUBLE: begin
                // left double enters edit with reverb on; right flips delay and trem
                if (!r_edit) begin
                    if (!evt.sw) begin
                        n_rev  = 1'b0;
                        n_edit = 1'b1;
                    end else begin
                        n_del  = !r_del;
                        n_trem = !r_trem;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev  <= 1'b1;
            r_del  <= 1'b1;
            r_trem <= 1'b1;
            r_edit <= 1'b0;
        end else if (fire) begin
            r_rev  <= n_rev;
            r_del  <= n_del;
            r_trem <= n_trem;
            r_edit <= n_edit;
        end
    end

    // Result register; mode flags only move on fire, so they hold with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_kind <= evt.kind;
            r_out_save <= n_save;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_press_kind      = r_out_kind;
    assign o_reverb_bypassed = r_rev;
    assign o_delay_bypassed  = r_del;
    assign o_trem_bypassed   = r_trem;
    assign o_edit_mode       = r_edit;
    assign o_save_request    = r_out_save;

    // Checks
    `FPC_ASSERT_SAME(a_save_is_normal, r_out_vld && r_out_save, r_out_kind == fpc_pkg::KIND_NORMAL, "save request without a normal press")
    `FPC_ASSERT_SAME(a_save_leaves_edit, r_out_vld && r_out_save, !r_edit, "save request while still in edit mode")
    `FPC_ASSERT_NEXT(a_fire_gives_result, fire, r_out_vld, "processed beat produced no result")
    `FPC_ASSERT_NEXT(a_stall_holds_input, o_stall, r_in_vld, "input register lost a beat under stall")

endmodule
